// ===== hw/rtl/twsa_pkg.sv =====
package twsa_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int SC_W     = 5;
    localparam int RC_W     = 3;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // register reset values
    localparam logic [SC_W-1:0] SC_RESET = 5'd8;
    localparam logic [RC_W-1:0] RC_RESET = 3'd1;

    // register indexes (paddr bit 2)
    localparam logic REG_SAMPLE_COUNT = 1'b0;
    localparam logic REG_REJECT_COUNT = 1'b1;

    // fewest values that may remain after trimming
    localparam int TRIM_MIN = 3;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_LOADJ,
        S_CAPJ,
        S_SCAN,
        S_MUL,
        S_ACC,
        S_TOTAL,
        S_DIV_LOAD,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

endpackage

// ===== hw/rtl/trimmed_weighted_sample_average.sv =====
// Trimmed, rank-weighted moving average of signed 1/16 degree samples. Each accepted
// sample goes into a ring of sample_count entries (0 acts as 1, values above
// MAX_SAMPLES saturate); until the ring has filled once, or for a one-entry ring,
// the raw sample comes back, with o_filled low until the fill. Otherwise the block
// ranks every ring entry against all others with one shared compare unit reading
// the ring memory one word per cycle, weights each kept rank with (m-1)+3*i through
// one shared multiplier, and divides by the total weight in a restoring divider,
// rounding to nearest with ties away from zero. Every word passes S_WRITE and S_OUT;
// a filtered word also passes the n-by-n rank scan of the n ring entries over the
// single ring read port, the weighting and the NUMW divider steps (26 at the default
// MAX_SAMPLES=16). One word is in flight at a time; o_ready is high only while idle.
// Writing either register restarts the ring fill. pready is always high.
module trimmed_weighted_sample_average #(
    parameter int MAX_SAMPLES = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // sample channel
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [twsa_pkg::SAMPLE_W-1:0]   i_sample,
    // result channel
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [twsa_pkg::SAMPLE_W-1:0]   o_average,
    output logic                                   o_filled,
    // register port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [twsa_pkg::APB_AW-1:0]            paddr,
    input  logic [twsa_pkg::APB_DW-1:0]            pwdata,
    output logic [twsa_pkg::APB_DW-1:0]            prdata,
    output logic                                   pready
);
    import twsa_pkg::*;

    localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int NW   = $clog2(MAX_SAMPLES + 1);
    localparam int WW   = NW + 2;
    localparam int TW   = 2 * NW + 3;
    localparam int ACCW = TW + SAMPLE_W;
    localparam int NUMW = ACCW + 1;
    localparam int DENW = TW + 1;
    localparam int BW   = $clog2(NUMW);
    localparam int PW   = SAMPLE_W + WW + 1;

    // state and registers
    t_state                      r_state, n_state;
    logic [SC_W-1:0]             r_sc, n_sc;
    logic [RC_W-1:0]             r_rej, n_rej;
    logic [AW-1:0]               r_pos, n_pos;
    logic                        r_full, n_full;
    logic signed [SAMPLE_W-1:0]  r_sample, n_sample;
    logic [AW-1:0]               r_j, n_j;
    logic [AW-1:0]               r_kd, n_kd;
    logic [AW-1:0]               r_cnt, n_cnt;
    logic signed [SAMPLE_W-1:0]  r_vj, n_vj;
    logic signed [ACCW-1:0]      r_prod, n_prod;
    logic signed [ACCW-1:0]      r_acc, n_acc;
    logic [TW-1:0]               r_total, n_total;
    logic [NUMW-1:0]             r_num, n_num;
    logic [DENW-1:0]             r_rem, n_rem;
    logic [DENW-1:0]             r_den, n_den;
    logic [BW-1:0]               r_bit, n_bit;
    logic                        r_neg, n_neg;
    logic signed [SAMPLE_W-1:0]  r_avg, n_avg;
    logic                        r_filled, n_filled;

    // ring memory
    logic signed [SAMPLE_W-1:0]  r_ring [MAX_SAMPLES];
    logic signed [SAMPLE_W-1:0]  r_rd_data;
    logic [AW-1:0]               rd_addr;
    logic                        ring_we;

    // derived values
    logic                        cfg_wr;
    logic [NW-1:0]               n_eff;
    logic [AW-1:0]               last_c;
    logic [AW-1:0]               pos_eff;
    logic [NW-1:0]               pos_inc;
    logic                        trim_c;
    logic [NW-1:0]               first_c;
    logic [NW-1:0]               m_c;
    logic [NW-1:0]               rank_off;
    logic                        in_rng;
    logic [WW-1:0]               weight;
    logic signed [PW-1:0]        prod_c;
    logic                        less_c;
    logic [TW:0]                 mm_c;
    logic [TW:0]                 mm5_c;
    logic [ACCW-1:0]             abs_c;
    logic [DENW:0]               rem_sh;
    logic                        qbit;
    logic [DENW:0]               rem_nx;
    logic [SAMPLE_W-1:0]         q_c;

    // register port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REJECT_COUNT) ? APB_DW'(r_rej) : APB_DW'(r_sc);

    // effective ring length
    always_comb begin
        if (r_sc == '0) begin
            n_eff = NW'(1);
        end else if (32'(r_sc) > MAX_SAMPLES) begin
            n_eff = NW'(MAX_SAMPLES);
        end else begin
            n_eff = NW'(r_sc);
        end
    end
    assign last_c = AW'(n_eff - 1'b1);

    // write position with wrap
    assign pos_eff = (NW'(r_pos) >= n_eff) ? '0 : r_pos;
    assign pos_inc = NW'(pos_eff) + 1'b1;

    // trimming window
    assign trim_c  = 8'(n_eff) >= 8'({r_rej, 1'b0}) + 8'(TRIM_MIN);
    assign first_c = trim_c ? NW'(r_rej) : '0;
    assign m_c     = trim_c ? n_eff - NW'({r_rej, 1'b0}) : n_eff;

    // rank compare, stable tie break on ring index
    assign less_c = (r_rd_data < r_vj) || ((r_rd_data == r_vj) && (r_kd < r_j));

    // weight of the ranked value
    assign rank_off = NW'(r_cnt) - first_c;
    assign in_rng   = (NW'(r_cnt) >= first_c) &&
                      ((NW + 1)'(r_cnt) < (NW + 1)'(first_c) + (NW + 1)'(m_c));
    assign weight   = WW'(m_c - 1'b1) + (WW'(rank_off) << 1) + WW'(rank_off);
    assign prod_c   = PW'(r_vj) * $signed({1'b0, weight});

    // total weight m(m-1)*5/2
    assign mm_c  = (TW + 1)'(m_c) * (TW + 1)'(m_c - 1'b1);
    assign mm5_c = (mm_c << 2) + mm_c;

    // divider step
    assign abs_c  = r_acc[ACCW-1] ? ACCW'(-r_acc) : ACCW'(r_acc);
    assign rem_sh = {r_rem, r_num[NUMW-1]};
    assign qbit   = rem_sh >= {1'b0, r_den};
    assign rem_nx = qbit ? rem_sh - {1'b0, r_den} : rem_sh;
    assign q_c    = r_num[SAMPLE_W-1:0];

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_sc     = r_sc;
        n_rej    = r_rej;
        n_pos    = r_pos;
        n_full   = r_full;
        n_sample = r_sample;
        n_j      = r_j;
        n_kd     = r_kd;
        n_cnt    = r_cnt;
        n_vj     = r_vj;
        n_prod   = r_prod;
        n_acc    = r_acc;
        n_total  = r_total;
        n_num    = r_num;
        n_rem    = r_rem;
        n_den    = r_den;
        n_bit    = r_bit;
        n_neg    = r_neg;
        n_avg    = r_avg;
        n_filled = r_filled;
        rd_addr  = '0;
        ring_we  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sample = i_sample;
                    n_state  = S_WRITE;
                end
            end
            S_WRITE: begin
                ring_we = 1'b1;
                n_acc   = '0;
                n_j     = '0;
                if (pos_inc >= n_eff) begin
                    n_pos  = '0;
                    n_full = 1'b1;
                end else begin
                    n_pos  = AW'(pos_inc);
                end
                if ((r_full || (pos_inc >= n_eff)) && (n_eff != NW'(1))) begin
                    n_state = S_LOADJ;
                end else begin
                    n_avg    = r_sample;
                    n_filled = r_full || (pos_inc >= n_eff);
                    n_state  = S_OUT;
                end
            end
            S_LOADJ: begin
                rd_addr = r_j;
                n_state = S_CAPJ;
            end
            S_CAPJ: begin
                n_vj    = r_rd_data;
                rd_addr = '0;
                n_kd    = '0;
                n_cnt   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_cnt = r_cnt + AW'(less_c);
                if (r_kd == last_c) begin
                    n_state = S_MUL;
                end else begin
                    rd_addr = r_kd + 1'b1;
                    n_kd    = r_kd + 1'b1;
                end
            end
            S_MUL: begin
                n_prod  = in_rng ? ACCW'(prod_c) : '0;
                n_state = S_ACC;
            end
            S_ACC: begin
                n_acc = r_acc + r_prod;
                if (r_j == last_c) begin
                    n_state = S_TOTAL;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_LOADJ;
                end
            end
            S_TOTAL: begin
                n_total = TW'(mm5_c >> 1);
                n_state = S_DIV_LOAD;
            end
            S_DIV_LOAD: begin
                n_num   = (NUMW'(abs_c) << 1) + NUMW'(r_total);
                n_den   = {r_total, 1'b0};
                n_rem   = '0;
                n_bit   = BW'(NUMW - 1);
                n_neg   = r_acc[ACCW-1];
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = rem_nx[DENW-1:0];
                n_num = {r_num[NUMW-2:0], qbit};
                if (r_bit == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_FIN: begin
                n_avg    = r_neg ? -$signed(q_c) : $signed(q_c);
                n_filled = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // register write restarts the ring fill
        if (cfg_wr) begin
            if (paddr[2] == REG_SAMPLE_COUNT) begin
                n_sc = pwdata[SC_W-1:0];
            end else begin
                n_rej = pwdata[RC_W-1:0];
            end
            n_pos  = '0;
            n_full = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sc    <= SC_RESET;
            r_rej   <= RC_RESET;
            r_pos   <= '0;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sc    <= n_sc;
            r_rej   <= n_rej;
            r_pos   <= n_pos;
            r_full  <= n_full;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_j      <= n_j;
        r_kd     <= n_kd;
        r_cnt    <= n_cnt;
        r_vj     <= n_vj;
        r_prod   <= n_prod;
        r_acc    <= n_acc;
        r_total  <= n_total;
        r_num    <= n_num;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_bit    <= n_bit;
        r_neg    <= n_neg;
        r_avg    <= n_avg;
        r_filled <= n_filled;
    end

    // ring memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[pos_eff] <= r_sample;
        end
        r_rd_data <= r_ring[rd_addr];
    end

    // handshake outputs
    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = (r_state == S_OUT);
    assign o_average = r_avg;
    assign o_filled  = r_filled;

endmodule

// ===== bench/trimmed_average_checker.sv =====
module trimmed_average_checker #(
    parameter int MAX_SAMPLES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // sample channel
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic signed [twsa_pkg::SAMPLE_W-1:0]  i_sample,
    // result channel
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [twsa_pkg::SAMPLE_W-1:0]  i_average,
    input  logic                                  i_filled,
    // register port
    input  logic                                  i_psel,
    input  logic                                  i_penable,
    input  logic                                  i_pwrite,
    input  logic                                  i_pready,
    input  logic [twsa_pkg::APB_AW-1:0]           i_paddr,
    input  logic [twsa_pkg::APB_DW-1:0]           i_pwdata,
    // status to the bench top
    output int                                    o_fail_count,
    output int                                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import twsa_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic                       filled;
    } t_average_word;

    // shadow of the registers and the ring
    logic [SC_W-1:0]             count_reg;
    logic [RC_W-1:0]             reject_reg;
    logic signed [SAMPLE_W-1:0]  history [MAX_SAMPLES];
    int                          slot;
    logic                        primed;

    t_average_word               expected_averages [$];
    t_average_word               oldest;
    int                          mismatch_count = 0;

    // ring entries in use: zero acts as one, large values saturate
    function automatic int ring_len();
        if (count_reg == 0) return 1;
        if (count_reg > MAX_SAMPLES) return MAX_SAMPLES;
        return int'(count_reg);
    endfunction

    // sort, trim if enough remain, rank-weighted mean rounded half away from zero
    function automatic logic signed [SAMPLE_W-1:0] ranked_mean(int n);
        int     vals [MAX_SAMPLES];
        int     lo, m, k, j, v;
        longint acc, total, quo;
        for (k = 0; k < n; k++) vals[k] = history[k];
        for (k = 1; k < n; k++) begin
            v = vals[k];
            j = k;
            while (j > 0 && vals[j-1] > v) begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = v;
        end
        lo = 0;
        m  = n;
        if (n >= 2 * int'(reject_reg) + TRIM_MIN) begin
            lo = int'(reject_reg);
            m  = n - 2 * int'(reject_reg);
        end
        if (m == 1) return SAMPLE_W'(vals[lo]);
        acc = 0;
        for (k = 0; k < m; k++) acc += longint'(vals[lo+k]) * longint'((m - 1) + 3 * k);
        total = (longint'(m) * longint'(m - 1) * 5) / 2;
        if (acc >= 0) quo = (2 * acc + total) / (2 * total);
        else quo = -((-2 * acc + total) / (2 * total));
        return quo[SAMPLE_W-1:0];
    endfunction

    // store the sample and work out the word it causes
    function automatic t_average_word advance_ring(logic signed [SAMPLE_W-1:0] sample);
        t_average_word w;
        int            n;
        n = ring_len();
        if (slot >= n) slot = 0;
        history[slot] = sample;
        slot++;
        if (slot >= n) begin
            slot   = 0;
            primed = 1'b1;
        end
        w.average = primed ? ranked_mean(n) : sample;
        w.filled  = primed;
        return w;
    endfunction

    // only the first few mismatches are printed
    task automatic note_mismatch(input string msg);
        if (mismatch_count < 10) $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // watch register writes and both channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            count_reg  = SC_RESET;
            reject_reg = RC_RESET;
            slot       = 0;
            primed     = 1'b0;
            foreach (history[k]) history[k] = '0;
            expected_averages.delete();
        end else begin
            // any register write restarts the fill
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_SAMPLE_COUNT) count_reg = i_pwdata[SC_W-1:0];
                else if (i_paddr[2] == REG_REJECT_COUNT) reject_reg = i_pwdata[RC_W-1:0];
                slot   = 0;
                primed = 1'b0;
            end
            // result word against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_averages.size() == 0) begin
                    note_mismatch($sformatf("unexpected word: average %0d filled %0b",
                                            i_average, i_filled));
                end else begin
                    oldest = expected_averages.pop_front();
                    if (i_average !== oldest.average)
                        note_mismatch($sformatf("average: expected %0d, got %0d",
                                                $signed(oldest.average), i_average));
                    if (i_filled !== oldest.filled)
                        note_mismatch($sformatf("filled: expected %0b, got %0b",
                                                oldest.filled, i_filled));
                end
            end
            // sample word
            if (i_in_valid && i_in_ready) expected_averages.push_back(advance_ring(i_sample));
        end
        o_pending    <= expected_averages.size();
        o_fail_count <= mismatch_count;
    end

endmodule

// ===== bench/trimmed_weighted_sample_average_tb.sv =====
module trimmed_weighted_sample_average_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import twsa_pkg::*;

    localparam int MAX_SAMPLES  = 16;
    localparam int PHASES       = 18;
    localparam int PHASE_WORDS  = 47;
    localparam int FORCED       = 8;
    // quiet stretch after the last words drain
    localparam int SETTLE_CYCLES = 400;
    localparam int DRAIN_LIMIT   = 20000;

    typedef enum int {MIX_ANY, MIX_EXTREME, MIX_CLUSTER, MIX_NEAR_ZERO} t_mix;

    logic                        i_clk;
    logic                        i_rst_n  = 1'b0;
    logic                        i_valid  = 1'b0;
    logic                        o_ready;
    logic signed [SAMPLE_W-1:0]  i_sample = '0;
    logic                        o_valid;
    logic                        i_ready  = 1'b0;
    logic signed [SAMPLE_W-1:0]  o_average;
    logic                        o_filled;
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [APB_AW-1:0]           paddr    = '0;
    logic [APB_DW-1:0]           pwdata   = '0;
    logic [APB_DW-1:0]           prdata;
    logic                        pready;

    int fail_count;
    int pending;
    int send_idle_pct  = 29;
    int ready_idle_pct = 86;

    trimmed_weighted_sample_average #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_sample  (i_sample),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_average (o_average),
        .o_filled  (o_filled),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    trimmed_average_checker #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_sample     (i_sample),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_average    (o_average),
        .i_filled     (o_filled),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 125 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= ready_idle_pct);
    end

    // one sample word, with random gaps before it
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        logic hs;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= value;
        hs = 1'b0;
        while (!hs) begin
            @(negedge i_clk);
            hs = o_ready;
            @(posedge i_clk);
        end
    endtask

    // setup then access cycle
    task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
        logic hs;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        hs = 1'b0;
        while (!hs) begin
            @(negedge i_clk);
            hs = pready;
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain outstanding words, then write both registers in random order
    task automatic configure(input int count, input int reject);
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || !o_ready);
        @(posedge i_clk);
        if ($urandom_range(0, 1)) begin
            write_reg(REG_SAMPLE_COUNT, APB_DW'(count));
            write_reg(REG_REJECT_COUNT, APB_DW'(reject));
        end else begin
            write_reg(REG_REJECT_COUNT, APB_DW'(reject));
            write_reg(REG_SAMPLE_COUNT, APB_DW'(count));
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input t_mix mix, input int centre);
        case (mix)
            MIX_ANY: begin
                return SAMPLE_W'($urandom_range(0, 4095));
            end
            MIX_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return SAMPLE_W'(-2048);
                    1: return SAMPLE_W'(2047);
                    2: return SAMPLE_W'(-1);
                    default: return '0;
                endcase
            end
            MIX_CLUSTER: begin
                return SAMPLE_W'(centre + int'($urandom_range(0, 6)) - 3);
            end
            default: begin
                return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
            end
        endcase
    endfunction

    // stimulus and verdict
    initial begin
        int   extreme_run [10] = '{2047, -2048, 2047, -2048, 0, -1, 1, 2047, -2048, -2048};
        int   single_run [3]   = '{5, -2048, 2047};
        int   short_run [5]    = '{-3, -1, -1, -2, 2047};
        // saturation, no trim possible, one entry, zero count, extremes of trim
        int   forced_count [FORCED]  = '{16, 31, 0, 17, 1, 3, 16, 2};
        int   forced_reject [FORCED] = '{7, 0, 3, 0, 7, 0, 6, 1};
        int   p, k, r, centre, count, reject, waited;
        t_mix mix;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: 8 entries, trim 1, extreme values
        foreach (extreme_run[k]) send_sample(SAMPLE_W'(extreme_run[k]));
        // zero count acts as a single entry
        configure(0, 1);
        foreach (single_run[k]) send_sample(SAMPLE_W'(single_run[k]));
        // too few entries to trim, so all four are averaged
        configure(4, 1);
        foreach (short_run[k]) send_sample(SAMPLE_W'(short_run[k]));

        for (p = 0; p < PHASES; p++) begin
            // idling pattern per third of the run
            if (p == PHASES / 3) begin
                send_idle_pct  = 86;
                ready_idle_pct = 29;
            end else if (p == 2 * PHASES / 3) begin
                send_idle_pct  = 0;
                ready_idle_pct = 0;
            end
            if (p < FORCED) begin
                count  = forced_count[p];
                reject = forced_reject[p];
            end else begin
                count  = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 8)
                                                       : $urandom_range(0, 31);
                reject = $urandom_range(0, 7);
            end
            configure(count, reject);
            centre = int'($urandom_range(0, 4080)) - 2040;
            for (k = 0; k < PHASE_WORDS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 40) mix = MIX_ANY;
                else if (r < 50) mix = MIX_EXTREME;
                else if (r < 80) mix = MIX_CLUSTER;
                else mix = MIX_NEAR_ZERO;
                send_sample(pick_sample(mix, centre));
            end
        end

        // wait for the last words, then a quiet stretch
        i_valid <= 1'b0;
        for (waited = 0; waited < DRAIN_LIMIT && pending != 0; waited++) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/twsa_pkg.sv
hw/rtl/trimmed_weighted_sample_average.sv
bench/trimmed_average_checker.sv
bench/trimmed_weighted_sample_average_tb.sv
